### hw/rtl/bucketed_sorted_key_lookup_core_defines.svh
// Assertion macros used by the bucketed key lookup checker.
`ifndef BUCKETED_SORTED_KEY_LOOKUP_CORE_DEFINES_SVH
`define BUCKETED_SORTED_KEY_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BSKL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BSKL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bskl_pkg.sv
// Package: shared types and fixed widths of the bucketed key lookup block.
`timescale 1ns / 1ps
`default_nettype none

package bskl_pkg;

    // Fixed field widths
    localparam int OPCODE_W        = 2;
    localparam int BUCKET_W        = 10;
    localparam int SLOT_W          = 7;
    localparam int KEY_W           = 64;
    localparam int FSLOT_W         = 6;
    localparam int SEEK_W          = 32;
    localparam int PREFIX_W        = 3;
    localparam int BYTE_BITS       = 8;
    localparam int PREFIX_MAX      = 4;
    localparam int PREFIX_BITS_MAX = PREFIX_MAX * BYTE_BITS;

    // Item operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_WRITE_KEY = 2'd0,
        OP_SET_COUNT = 2'd1,
        OP_LOOKUP    = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCALE,
        ST_BASE,
        ST_LOAD,
        ST_PROBE,
        ST_CMP,
        ST_FINISH
    } fsm_state_t;

endpackage

`default_nettype wire

### hw/rtl/bskl_req_if.sv
// Interface: request channel (load and lookup items).
`timescale 1ns / 1ps
`default_nettype none

interface bskl_req_if
    import bskl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BUCKET_W-1:0] bucket;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key;

    modport source (output valid, output opcode, output bucket, output slot, output key,
                    input ready);
    modport sink   (input valid, input opcode, input bucket, input slot, input key,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/bskl_rsp_if.sv
// Interface: response channel (one result item per request item).
`timescale 1ns / 1ps
`default_nettype none

interface bskl_rsp_if
    import bskl_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                found;
    logic [BUCKET_W-1:0] home_bucket;
    logic [FSLOT_W-1:0]  found_slot;
    logic [SEEK_W-1:0]   seek_count;

    modport source (output valid, output found, output home_bucket, output found_slot,
                    output seek_count, input ready);
    modport sink   (input valid, input found, input home_bucket, input found_slot,
                    input seek_count, output ready);
endinterface

`default_nettype wire

### hw/rtl/bskl_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module bskl_ram #(
    parameter int DEPTH  = 2,
    parameter int WIDTH  = 1,
    parameter int ADDR_W = $clog2(DEPTH)
)(
    input  wire              clk,
    input  wire              we,
    input  wire [ADDR_W-1:0] waddr,
    input  wire [WIDTH-1:0]  wdata,
    input  wire              re,
    input  wire [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bskl_bucket_calc.sv
// Bucket index unit: key prefix times bucket count, scaled down by the prefix width.
`timescale 1ns / 1ps
`default_nettype none

module bskl_bucket_calc
    import bskl_pkg::*;
#(
    parameter int NUM_BUCKET = 2,
    parameter int KEY_BITS   = 64,
    parameter int IDX_W      = $clog2(NUM_BUCKET)
)(
    input  wire                clk,
    input  wire                en,
    input  wire [KEY_BITS-1:0] key,
    input  wire [PREFIX_W-1:0] pbytes,
    output logic [IDX_W-1:0]   bidx
);

    localparam int NB_W   = $clog2(NUM_BUCKET + 1);
    localparam int PROD_W = PREFIX_BITS_MAX + NB_W;

    logic [PREFIX_BITS_MAX-1:0] prefix;
    logic [PROD_W-1:0]          prod_reg;
    logic [PREFIX_W-1:0]        pb_reg;

    // Leading bytes of the key, pbytes is already limited to 1..4
    always_comb
    begin
        case (pbytes)
            3'd1:    prefix = PREFIX_BITS_MAX'(key[KEY_BITS-1 -: BYTE_BITS]);
            3'd2:    prefix = PREFIX_BITS_MAX'(key[KEY_BITS-1 -: 2*BYTE_BITS]);
            3'd3:    prefix = PREFIX_BITS_MAX'(key[KEY_BITS-1 -: 3*BYTE_BITS]);
            default: prefix = PREFIX_BITS_MAX'(key[KEY_BITS-1 -: 4*BYTE_BITS]);
        endcase
    end

    // Multiply stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(prefix) * PROD_W'(NUM_BUCKET);
            pb_reg   <= pbytes;
        end
    end

    // Scale back by 8 bits per prefix byte; result is always below NUM_BUCKET
    always_comb
    begin
        case (pb_reg)
            3'd1:    bidx = prod_reg[BYTE_BITS +: IDX_W];
            3'd2:    bidx = prod_reg[2*BYTE_BITS +: IDX_W];
            3'd3:    bidx = prod_reg[3*BYTE_BITS +: IDX_W];
            default: bidx = prod_reg[4*BYTE_BITS +: IDX_W];
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/bucketed_sorted_key_lookup_core.sv
// Bucketed key lookup: top level with sequencer, shared compare unit and stores.
//
// Usage:
//  - req channel (valid/ready) carries one item: opcode, bucket, slot, key.
//    Opcode write-key stores key in (bucket, slot); set-count sets the bucket's
//    record count; lookup hashes the key prefix to a bucket and binary-searches it.
//  - rsp channel (valid/ready) returns one item per request: found, home_bucket,
//    found_slot and the running seek_count.
//  - cfg_we/cfg_wdata writes the prefix length register; write it only while idle.
//  - One item is in work at a time; req.ready is high only when the sequencer idles.
//  - Sequence: a load passes EXEC and FINISH before rsp.valid rises. A lookup passes
//    EXEC, SCALE, BASE and LOAD, then PROBE and CMP for each probe, and ends in FINISH;
//    a miss ends with one more PROBE. The probe count is at most ceil(log2(SLOTS+1)),
//    7 for 64 slots. Each probe is one key memory read plus one pass through the shared
//    64-bit compare unit. req.ready is back in the cycle rsp.valid rises, unless a
//    stalled earlier result holds the sequencer in FINISH.
//  - After reset the bucket count store is cleared one entry per cycle, all NUM_BUCKET
//    entries, with req.ready low. Keys are not cleared and must be written first.
//  - A finished result sits in the output register; the next item is accepted
//    while it waits. A stalled rsp holds the sequencer at its final step.
`timescale 1ns / 1ps
`default_nettype none

module bucketed_sorted_key_lookup_core
    import bskl_pkg::*;
#(
    parameter int NUM_BUCKET       = 1024,
    parameter int SLOTS_PER_BUCKET = 64,
    parameter int KEY_BYTES        = 8
)(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire [PREFIX_W-1:0] cfg_wdata,
    bskl_req_if.sink           req,
    bskl_rsp_if.source         rsp
);

    localparam int KEY_BITS = KEY_BYTES * BYTE_BITS;
    localparam int IDX_W    = $clog2(NUM_BUCKET);
    localparam int CNT_W    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int DEPTH    = NUM_BUCKET * SLOTS_PER_BUCKET;
    localparam int AW       = $clog2(DEPTH);
    localparam int CMP_W    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    localparam logic [CMP_W-1:0] SLOTS_C  = CMP_W'(SLOTS_PER_BUCKET);
    localparam logic [IDX_W-1:0] LAST_BKT = IDX_W'(NUM_BUCKET - 1);

    fsm_state_t state_reg, state_next;

    // Item registers
    op_t                 op_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [KEY_BITS-1:0] key_reg;

    // Search registers
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [IDX_W-1:0] bidx_reg;
    logic [AW-1:0]    base_reg;
    logic             found_reg, found_next;

    // Control and output registers
    logic [IDX_W-1:0]    clr_idx_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    logic [SEEK_W-1:0]   seek_reg, seek_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg;
    logic [BUCKET_W-1:0] out_bidx_reg;
    logic [FSLOT_W-1:0]  out_fslot_reg;
    logic [SEEK_W-1:0]   out_seek_reg;

    // Strobes from the sequencer
    logic in_ready;
    logic calc_en;
    logic key_we;
    logic cnt_we;
    logic cnt_re;
    logic key_re;
    logic out_load;

    // Datapath wires
    logic [PREFIX_W-1:0] p_eff;
    logic [IDX_W-1:0]    calc_bidx;
    logic                bkt_ok;
    logic                slot_ok;
    logic [AW-1:0]       wr_addr;
    logic [CMP_W-1:0]    slot_x;
    logic [CMP_W-1:0]    cnt_lim;
    logic [IDX_W-1:0]    cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [CNT_W-1:0]    cnt_rdata;
    logic [KEY_BITS-1:0] key_rdata;
    logic [CNT_W-1:0]    mid_c;
    logic [AW-1:0]       probe_addr;
    logic                range_open;
    logic                key_eq;
    logic                key_lt;

    // Prefix register value limited to 1..4
    always_comb
    begin
        if (prefix_reg inside {[3'd1:3'd4]})
        begin
            p_eff = prefix_reg;
        end
        else if (prefix_reg == '0)
        begin
            p_eff = PREFIX_W'(1);
        end
        else
        begin
            p_eff = PREFIX_W'(PREFIX_MAX);
        end
    end

    // Load address checks and count limit
    assign bkt_ok    = 32'(bucket_reg) < 32'(NUM_BUCKET);
    assign slot_ok   = 32'(slot_reg) < 32'(SLOTS_PER_BUCKET);
    assign wr_addr   = AW'(32'(bucket_reg) * 32'(SLOTS_PER_BUCKET) + 32'(slot_reg));
    assign slot_x    = CMP_W'(slot_reg);
    assign cnt_lim   = (slot_x > SLOTS_C) ? SLOTS_C : slot_x;
    assign cnt_waddr = (state_reg == ST_CLEAR) ? clr_idx_reg : IDX_W'(bucket_reg);
    assign cnt_wdata = (state_reg == ST_CLEAR) ? '0 : CNT_W'(cnt_lim);

    // Shared compare unit: range test and key compare of one probe
    assign range_open = lo_reg < hi_reg;
    assign mid_c      = CNT_W'(lo_reg + ((hi_reg - lo_reg - CNT_W'(1)) >> 1));
    assign probe_addr = base_reg + AW'(mid_c);
    assign key_eq     = key_rdata == key_reg;
    assign key_lt     = key_rdata < key_reg;

    bskl_bucket_calc #(
        .NUM_BUCKET (NUM_BUCKET),
        .KEY_BITS   (KEY_BITS),
        .IDX_W      (IDX_W)
    ) u_bucket_calc (
        .clk    (clk),
        .en     (calc_en),
        .key    (key_reg),
        .pbytes (p_eff),
        .bidx   (calc_bidx)
    );

    bskl_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (KEY_BITS),
        .ADDR_W (AW)
    ) u_key_mem (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_reg),
        .re    (key_re),
        .raddr (probe_addr),
        .rdata (key_rdata)
    );

    bskl_ram #(
        .DEPTH  (NUM_BUCKET),
        .WIDTH  (CNT_W),
        .ADDR_W (IDX_W)
    ) u_cnt_mem (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (bidx_reg),
        .rdata (cnt_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_idx_reg == LAST_BKT)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (op_reg == OP_LOOKUP) ? ST_SCALE : ST_FINISH;
            end
            ST_SCALE:  state_next = ST_BASE;
            ST_BASE:   state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_PROBE;
            ST_PROBE:
            begin
                state_next = range_open ? ST_CMP : ST_FINISH;
            end
            ST_CMP:
            begin
                state_next = key_eq ? ST_FINISH : ST_PROBE;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer strobes
    always_comb
    begin
        in_ready = 1'b0;
        calc_en  = 1'b0;
        key_we   = 1'b0;
        cnt_we   = 1'b0;
        cnt_re   = 1'b0;
        key_re   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_CLEAR:  cnt_we = 1'b1;
            ST_IDLE:   in_ready = 1'b1;
            ST_EXEC:
            begin
                calc_en = (op_reg == OP_LOOKUP);
                key_we  = (op_reg == OP_WRITE_KEY) && bkt_ok && slot_ok;
                cnt_we  = (op_reg == OP_SET_COUNT) && bkt_ok;
            end
            ST_BASE:   cnt_re = 1'b1;
            ST_PROBE:  key_re = range_open;
            ST_FINISH: out_load = !out_valid_reg || rsp.ready;
            default:   in_ready = 1'b0;
        endcase
    end

    // Search datapath next values
    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        found_next = found_reg;
        case (state_reg)
            ST_EXEC:   found_next = 1'b0;
            ST_LOAD:
            begin
                lo_next = '0;
                hi_next = cnt_rdata;
            end
            ST_PROBE:  mid_next = mid_c;
            ST_CMP:
            begin
                if (key_eq)
                begin
                    found_next = 1'b1;
                end
                else if (key_lt)
                begin
                    lo_next = CNT_W'(mid_reg + CNT_W'(1));
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            default:   lo_next = lo_reg;
        endcase
    end

    // Output handshake and lookup counter
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        seek_next      = seek_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (op_reg == OP_LOOKUP)
            begin
                seek_next = seek_reg + SEEK_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            prefix_reg    <= PREFIX_W'(1);
            seek_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seek_reg      <= seek_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= IDX_W'(clr_idx_reg + IDX_W'(1));
            end
            if (cfg_we)
            begin
                prefix_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && req.valid)
        begin
            op_reg     <= op_t'(req.opcode);
            bucket_reg <= req.bucket;
            slot_reg   <= req.slot;
            key_reg    <= req.key[KEY_BITS-1:0];
        end
        if (state_reg == ST_SCALE)
        begin
            bidx_reg <= calc_bidx;
        end
        if (state_reg == ST_BASE)
        begin
            base_reg <= AW'(32'(bidx_reg) * 32'(SLOTS_PER_BUCKET));
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        if (out_load)
        begin
            out_found_reg <= (op_reg == OP_LOOKUP) && found_reg;
            out_bidx_reg  <= (op_reg == OP_LOOKUP) ? BUCKET_W'(bidx_reg) : '0;
            out_fslot_reg <= ((op_reg == OP_LOOKUP) && found_reg) ? FSLOT_W'(mid_reg) : '0;
            out_seek_reg  <= seek_next;
        end
    end

    assign req.ready        = in_ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_found_reg;
    assign rsp.home_bucket  = out_bidx_reg;
    assign rsp.found_slot   = out_fslot_reg;
    assign rsp.seek_count   = out_seek_reg;

endmodule

`default_nettype wire

### hw/rtl/bskl_checker.sv
// Checker: port-level properties of the bucketed key lookup, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "bucketed_sorted_key_lookup_core_defines.svh"

module bskl_checker
    import bskl_pkg::*;
(
    input wire               clk,
    input wire               rst_n,
    input wire               req_valid,
    input wire               req_ready,
    input wire               rsp_valid,
    input wire               rsp_ready,
    input wire               rsp_found,
    input wire [FSLOT_W-1:0] rsp_found_slot,
    input wire [SEEK_W-1:0]  rsp_seek_count
);

    logic [SEEK_W-1:0] seek_prev_reg;
    logic              has_prev_reg;

    // Track the seek count of the last delivered item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seek_prev_reg <= '0;
            has_prev_reg  <= 1'b0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            seek_prev_reg <= rsp_seek_count;
            has_prev_reg  <= 1'b1;
        end
    end

    // Consecutive results advance the seek count by at most one
    `BSKL_ASSERT_SAME(a_seek_step, rsp_valid && has_prev_reg, (rsp_seek_count == seek_prev_reg) || (rsp_seek_count == seek_prev_reg + 32'd1), "seek_count skipped or went back")

    // A miss or a load reports slot zero
    `BSKL_ASSERT_SAME(a_miss_slot, rsp_valid && !rsp_found, rsp_found_slot == '0, "found_slot set without a match")

    // Only one item in work at a time
    `BSKL_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready, "ready stayed high after accept")

    // A stalled result holds
    `BSKL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_seek_count), "stalled result changed")

endmodule

bind bucketed_sorted_key_lookup_core bskl_checker u_bskl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_found      (rsp.found),
    .rsp_found_slot (rsp.found_slot),
    .rsp_seek_count (rsp.seek_count)
);

`default_nettype wire

### verif/tb_bucketed_sorted_key_lookup_core.sv
// Testbench: randomized load and lookup traffic against a bucketed key search predictor.
`timescale 1ns / 1ps

module tb_bucketed_sorted_key_lookup_core;
    import bskl_pkg::*;

    localparam int BUCKET_TOTAL = 1024;
    localparam int SLOTS       = 64;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 158;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT_NS    = 5_000_000;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [BUCKET_W-1:0] bucket;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    key;
    } req_item_t;

    typedef struct packed {
        logic                found;
        logic [BUCKET_W-1:0] home_bucket;
        logic [FSLOT_W-1:0]  found_slot;
        logic [SEEK_W-1:0]   seek_count;
    } lookup_result_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [PREFIX_W-1:0] cfg_wdata;

    bskl_req_if req_ch();
    bskl_rsp_if rsp_ch();

    bucketed_sorted_key_lookup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Items waiting to be driven, and results owed by the block
    req_item_t      req_items[$];
    lookup_result_t rsp_expected[$];

    // Predictor state
    bit [KEY_W-1:0]    key_mem [0:BUCKET_TOTAL*SLOTS-1];
    bit [SLOT_W-1:0]   count_mem [0:BUCKET_TOTAL-1];
    bit [SEEK_W-1:0]   lookup_total;
    bit [PREFIX_W-1:0] prefix_reg = 3'd1;

    // Stimulus plan: what the block will hold once queued items are taken
    bit [KEY_W-1:0]    plan_keys [0:BUCKET_TOTAL*SLOTS-1];
    bit [SLOTS-1:0]    plan_written [0:BUCKET_TOTAL-1];
    bit [SLOT_W-1:0]   plan_count [0:BUCKET_TOTAL-1];
    int                live_buckets[$];
    int                queued_items;

    bit [PREFIX_W-1:0] prefix_plan [PHASES] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd4,
                                                3'd3, 3'd5, 3'd6, 3'd1};

    int send_idle_pct;
    int recv_idle_pct;
    bit rsp_hold;
    bit req_taken;
    int mismatches;
    int results_checked;
    int lookups_seen;
    int hits_seen;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // Predictor: one result per accepted item
    task automatic predict_item(input req_item_t it);
        lookup_result_t r;
        int             p;
        int             lo;
        int             hi;
        int             mid;
        logic [63:0]    prefix;
        logic [63:0]    scaled;
        logic [KEY_W-1:0] probe;
        r = '0;
        case (it.opcode)
            OP_WRITE_KEY:
                if (it.slot < SLOTS)
                    key_mem[{it.bucket, it.slot[FSLOT_W-1:0]}] = it.key;
            OP_SET_COUNT:
                count_mem[it.bucket] = (it.slot > SLOTS) ? SLOT_W'(SLOTS) : it.slot;
            OP_LOOKUP:
            begin
                lookup_total++;
                p = (prefix_reg < 1) ? 1 : (prefix_reg > PREFIX_MAX) ? PREFIX_MAX
                                                                    : int'(prefix_reg);
                prefix = (it.key >> ((8 - p) * BYTE_BITS))
                         & ((64'd1 << (p * BYTE_BITS)) - 64'd1);
                scaled = (prefix * BUCKET_TOTAL) >> (p * BYTE_BITS);
                if (scaled >= BUCKET_TOTAL)
                    scaled = BUCKET_TOTAL - 1;
                r.home_bucket = scaled[BUCKET_W-1:0];
                // binary search over the bucket's counted slots
                lo = 0;
                hi = int'(count_mem[r.home_bucket]) - 1;
                while (lo <= hi)
                begin
                    mid = lo + (hi - lo) / 2;
                    probe = key_mem[{r.home_bucket, mid[FSLOT_W-1:0]}];
                    if (probe == it.key)
                    begin
                        r.found = 1'b1;
                        r.found_slot = mid[FSLOT_W-1:0];
                        break;
                    end
                    else if (probe < it.key)
                        lo = mid + 1;
                    else
                        hi = mid - 1;
                end
            end
            default: ;
        endcase
        r.seek_count = lookup_total;
        rsp_expected.push_back(r);
    endtask

    // Sample config writes and accepted items at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            prefix_reg = cfg_wdata;
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            predict_item({req_ch.opcode, req_ch.bucket, req_ch.slot, req_ch.key});
            req_taken = 1'b1;
        end
    end

    // Request driver
    always @(negedge clk)
    begin
        req_item_t nxt;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            req_taken = 1'b0;
            if (req_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = req_items.pop_front();
                req_ch.valid  <= 1'b1;
                req_ch.opcode <= nxt.opcode;
                req_ch.bucket <= nxt.bucket;
                req_ch.slot   <= nxt.slot;
                req_ch.key    <= nxt.key;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response ready, with random stalls and the long hold-off
    always @(negedge clk)
        rsp_ch.ready <= !rsp_hold && ($urandom_range(0, 99) >= recv_idle_pct);

    // Result checker
    always @(posedge clk)
    begin
        lookup_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (rsp_expected.size() == 0)
                report_mismatch("result with nothing outstanding", rsp_ch.seek_count, 0);
            else
            begin
                want = rsp_expected.pop_front();
                results_checked++;
                if (want.found)
                    hits_seen++;
                if (rsp_ch.found !== want.found)
                    report_mismatch("found", rsp_ch.found, want.found);
                if (rsp_ch.home_bucket !== want.home_bucket)
                    report_mismatch("home_bucket", rsp_ch.home_bucket, want.home_bucket);
                if (rsp_ch.found_slot !== want.found_slot)
                    report_mismatch("found_slot", rsp_ch.found_slot, want.found_slot);
                if (rsp_ch.seek_count !== want.seek_count)
                    report_mismatch("seek_count", rsp_ch.seek_count, want.seek_count);
            end
        end
    end

    // Queue one item and track what the block will hold after it
    task automatic queue_item(input logic [OPCODE_W-1:0] op, input logic [BUCKET_W-1:0] b,
                              input logic [SLOT_W-1:0] s, input logic [KEY_W-1:0] k);
        req_items.push_back({op, b, s, k});
        queued_items++;
        if (op == OP_LOOKUP)
            lookups_seen++;
        if (op == OP_WRITE_KEY && s < SLOTS)
        begin
            plan_keys[{b, s[FSLOT_W-1:0]}] = k;
            plan_written[b][s[FSLOT_W-1:0]] = 1'b1;
        end
        else if (op == OP_SET_COUNT)
        begin
            plan_count[b] = (s > SLOTS) ? SLOT_W'(SLOTS) : s;
            if (s != 0)
                live_buckets.push_back(int'(b));
        end
    endtask

    // Number of slots written from slot 0 upward without a gap
    function automatic int written_run(input logic [BUCKET_W-1:0] b);
        int n;
        n = 0;
        while (n < SLOTS && plan_written[b][n])
            n++;
        return n;
    endfunction

    // Write n keys in non-decreasing order into a bucket, then set its count
    task automatic fill_bucket(input logic [BUCKET_W-1:0] b, input int n,
                               input logic [SLOT_W-1:0] cnt);
        logic [KEY_W-1:0] keys [0:SLOTS-1];
        logic [53:0]      low;
        bit               down;
        int               i;
        int               idx;
        low = 54'({$urandom_range(0, 1023), $urandom});
        for (i = 0; i < n; i++)
        begin
            keys[i] = {b, low};
            if ($urandom_range(0, 15) != 0)
                low = low + 54'({$urandom_range(0, 255), $urandom}) + 54'd1;
        end
        down = $urandom_range(0, 1);
        for (i = 0; i < n; i++)
        begin
            idx = down ? n - 1 - i : i;
            queue_item(OP_WRITE_KEY, b, SLOT_W'(idx), keys[idx]);
        end
        queue_item(OP_SET_COUNT, b, cnt, {$urandom, $urandom});
    endtask

    // Lookup: stored keys, near misses and stray keys
    task automatic queue_lookup();
        int               r;
        logic [BUCKET_W-1:0] b;
        logic [SLOT_W-1:0]   c;
        logic [KEY_W-1:0]    k;
        r = $urandom_range(0, 99);
        k = {$urandom, $urandom};
        if (live_buckets.size() != 0 && r < 80)
        begin
            b = BUCKET_W'(live_buckets[$urandom_range(0, live_buckets.size() - 1)]);
            c = plan_count[b];
            if (r < 60 && c != 0)
            begin
                k = plan_keys[{b, FSLOT_W'($urandom_range(0, int'(c) - 1))}];
                if (r >= 50)
                    k = $urandom_range(0, 1) ? k + 64'd1 : k - 64'd1;
            end
            else
                k = {b, k[53:0]};
        end
        else if (r >= 95)
            k = $urandom_range(0, 1) ? '0 : '1;
        queue_item(OP_LOOKUP, BUCKET_W'($urandom), SLOT_W'($urandom), k);
    endtask

    // Random phase traffic
    task automatic fill_phase(input int target);
        int                  start;
        int                  r;
        int                  n;
        int                  run;
        logic [BUCKET_W-1:0] b;
        logic [SLOT_W-1:0]   cnt;
        start = queued_items;
        while (queued_items - start < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                // well-formed bucket load, mostly on buckets reachable at every prefix
                b = ($urandom_range(0, 3) != 0) ? BUCKET_W'({$urandom_range(0, 255), 2'b00})
                                                : BUCKET_W'($urandom);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
                cnt = SLOT_W'(n);
                if (n == SLOTS && $urandom_range(0, 1))
                    cnt = SLOT_W'($urandom_range(65, 127));
                else if ($urandom_range(0, 6) == 0)
                    cnt = SLOT_W'($urandom_range(0, n));
                fill_bucket(b, n, cnt);
            end
            else if (r < 17)
            begin
                // count change, kept within the written run of slots
                b = (live_buckets.size() != 0 && $urandom_range(0, 1))
                    ? BUCKET_W'(live_buckets[$urandom_range(0, live_buckets.size() - 1)])
                    : BUCKET_W'($urandom);
                run = written_run(b);
                cnt = SLOT_W'($urandom_range(0, run));
                if (run == SLOTS && $urandom_range(0, 1))
                    cnt = SLOT_W'($urandom_range(65, 127));
                queue_item(OP_SET_COUNT, b, cnt, {$urandom, $urandom});
            end
            else if (r < 19)
                queue_item(OP_UNUSED, BUCKET_W'($urandom), SLOT_W'($urandom),
                           {$urandom, $urandom});
            else if (r < 21)
                queue_item(OP_WRITE_KEY, BUCKET_W'($urandom), SLOT_W'($urandom_range(64, 127)),
                           {$urandom, $urandom});
            else if (r < 24)
                queue_item(OP_WRITE_KEY, BUCKET_W'($urandom), SLOT_W'($urandom_range(0, 63)),
                           {$urandom, $urandom});
            else
                queue_lookup();
        end
    endtask

    task automatic wait_drained();
        while (req_items.size() != 0 || req_ch.valid || rsp_expected.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus and phase control
    initial
    begin
        int ph;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = '0;
        req_ch.bucket = '0;
        req_ch.slot   = '0;
        req_ch.key    = '0;
        rsp_ch.ready  = 1'b0;
        rsp_hold      = 1'b0;
        req_taken     = 1'b0;

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                wait_drained();
                repeat (4) @(negedge clk);
                cfg_we    <= 1'b1;
                cfg_wdata <= prefix_plan[ph];
                @(negedge clk);
                cfg_we    <= 1'b0;
            end
            send_idle_pct = (ph < 3) ? 28 : (ph < 6) ? 59 : 0;
            recv_idle_pct = (ph < 3) ? 59 : (ph < 6) ? 28 : 0;

            if (ph == 0)
            begin
                // smallest and largest keys and buckets
                queue_item(OP_WRITE_KEY, 10'd0, 7'd0, 64'd0);
                queue_item(OP_SET_COUNT, 10'd0, 7'd1, '1);
                queue_item(OP_LOOKUP, 10'd0, 7'd0, 64'd0);
                queue_item(OP_LOOKUP, '1, '1, 64'd1);
                queue_item(OP_WRITE_KEY, 10'd1020, 7'd0, '1);
                queue_item(OP_SET_COUNT, 10'd1020, 7'd1, 64'd0);
                queue_item(OP_LOOKUP, 10'd0, 7'd0, '1);
                queue_item(OP_WRITE_KEY, 10'd1023, 7'd63, 64'h5);
                queue_item(OP_WRITE_KEY, 10'd1023, 7'd0, '1);
                queue_item(OP_SET_COUNT, 10'd1023, 7'd1, 64'd0);
                // empty bucket misses
                queue_item(OP_LOOKUP, 10'd3, 7'd5, 64'h4000_0000_0000_0000);
                // slot outside the bucket is dropped
                queue_item(OP_WRITE_KEY, 10'd0, 7'd64, 64'h7);
                queue_item(OP_WRITE_KEY, 10'd0, 7'd127, 64'h9);
                queue_item(OP_LOOKUP, 10'd0, 7'd0, 64'd0);
                // unused opcode answers like a load
                queue_item(OP_UNUSED, '1, '1, '1);
                // count back to zero misses, then restore
                queue_item(OP_SET_COUNT, 10'd0, 7'd0, 64'd0);
                queue_item(OP_LOOKUP, 10'd0, 7'd0, 64'd0);
                queue_item(OP_SET_COUNT, 10'd0, 7'd1, 64'd0);
                queue_item(OP_LOOKUP, 10'd0, 7'd0, 64'd0);
                // full bucket with a count beyond the slot range
                fill_bucket(10'd8, SLOTS, 7'd127);
                queue_lookup();
                queue_lookup();
            end

            fill_phase(PHASE_ITEMS);

            // long output hold-off while the sender keeps offering
            if (ph == 1 || ph == 7)
            begin
                @(posedge clk);
                rsp_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_hold = 1'b0;
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Checked %0d results: %0d lookups with %0d hits, across %0d prefix settings",
                 results_checked, lookups_seen, hits_seen, PHASES);
        $display("Traffic mixed bucket loads, count changes, dropped writes and both stall sides");
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Reset: held low from the start, released once
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Watchdog
    initial
    begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/bskl_pkg.sv
hw/rtl/bskl_req_if.sv
hw/rtl/bskl_rsp_if.sv
hw/rtl/bskl_ram.sv
hw/rtl/bskl_bucket_calc.sv
hw/rtl/bucketed_sorted_key_lookup_core.sv
hw/rtl/bskl_checker.sv
verif/tb_bucketed_sorted_key_lookup_core.sv
